// File: src/euq_pkg.sv
package euq_pkg;

  // cordic datapath widths: x, y in q30, z in phase units (2^32 per turn)
  localparam int XW = 32;
  localparam int ZW = 33;
  localparam int SUMW = XW + 1;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // 1/gain in q30
  localparam logic signed [XW-1:0] CORDIC_X0 = 32'sd652032874;
  localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

  // atan(2^-k) in phase units, rounded
  localparam logic [31:0] ATAN_PHASE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81,
    32'd41, 32'd20, 32'd10, 32'd5,
    32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  // index 0 roll, 1 pitch, 2 yaw
  typedef lane_t [2:0] lanes_t;

  localparam int LANE_ROLL = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW = 2;

  // q30 product, rounded half up
  function automatic logic signed [XW-1:0] qmul(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + Q30_HALF;
    return p[61:30];
  endfunction

endpackage

// File: src/euq_cordic_cell.sv
module euq_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  euq_pkg::lanes_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output euq_pkg::lanes_t dn_data
);

  localparam int K = STEP % 32;
  localparam logic signed [euq_pkg::ZW-1:0] ATAN_K =
    euq_pkg::ZW'(euq_pkg::ATAN_PHASE[K]);

  logic            valid_r;
  euq_pkg::lanes_t data_r;
  euq_pkg::lanes_t data_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      // both shifts use the values from before the rotation
      if (!up_data[l].z[euq_pkg::ZW-1]) begin
        data_nxt[l].x = up_data[l].x - (up_data[l].y >>> K);
        data_nxt[l].y = up_data[l].y + (up_data[l].x >>> K);
        data_nxt[l].z = up_data[l].z - ATAN_K;
      end else begin
        data_nxt[l].x = up_data[l].x + (up_data[l].y >>> K);
        data_nxt[l].y = up_data[l].y - (up_data[l].x >>> K);
        data_nxt[l].z = up_data[l].z + ATAN_K;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;

endmodule

// File: src/euq_combine.sv
module euq_combine #(
  parameter int OUT_BITS = euq_pkg::OUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  euq_pkg::lanes_t            up_data,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic signed [OUT_BITS-1:0] dn_w,
  output logic signed [OUT_BITS-1:0] dn_x,
  output logic signed [OUT_BITS-1:0] dn_y,
  output logic signed [OUT_BITS-1:0] dn_z
);

  localparam int XW = euq_pkg::XW;
  localparam int SUMW = euq_pkg::SUMW;
  localparam int RW = SUMW + 2;
  localparam logic signed [RW-1:0] LIM = (RW'(1) <<< (OUT_BITS - 1)) - RW'(1);

  typedef logic signed [XW-1:0] q30_t;
  typedef logic signed [SUMW-1:0] sum_t;
  typedef logic signed [OUT_BITS-1:0] comp_t;

  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;

  // stage a: pair products and carried yaw terms
  q30_t cc_r, ss_r, sc_r, cs_r, cy_r, sy_r;
  // stage b: the eight three-way terms
  q30_t tw1_r, tw2_r, tx1_r, tx2_r, ty1_r, ty2_r, tz1_r, tz2_r;
  // stage c: output word
  comp_t w_r, x_r, y_r, z_r;

  q30_t cr, sr, cp, sp;

  assign cr = up_data[euq_pkg::LANE_ROLL].x;
  assign sr = up_data[euq_pkg::LANE_ROLL].y;
  assign cp = up_data[euq_pkg::LANE_PITCH].x;
  assign sp = up_data[euq_pkg::LANE_PITCH].y;

  assign rdy_c = !vc_r || dn_ready;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      cc_r <= euq_pkg::qmul(cr, cp);
      ss_r <= euq_pkg::qmul(sr, sp);
      sc_r <= euq_pkg::qmul(sr, cp);
      cs_r <= euq_pkg::qmul(cr, sp);
      cy_r <= up_data[euq_pkg::LANE_YAW].x;
      sy_r <= up_data[euq_pkg::LANE_YAW].y;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      tw1_r <= euq_pkg::qmul(cc_r, cy_r);
      tw2_r <= euq_pkg::qmul(ss_r, sy_r);
      tx1_r <= euq_pkg::qmul(sc_r, cy_r);
      tx2_r <= euq_pkg::qmul(cs_r, sy_r);
      ty1_r <= euq_pkg::qmul(cs_r, cy_r);
      ty2_r <= euq_pkg::qmul(sc_r, sy_r);
      tz1_r <= euq_pkg::qmul(cc_r, sy_r);
      tz2_r <= euq_pkg::qmul(ss_r, cy_r);
    end
  end

  sum_t sum_w, sum_x, sum_y, sum_z;

  assign sum_w = SUMW'(tw1_r) + SUMW'(tw2_r);
  assign sum_x = SUMW'(tx1_r) - SUMW'(tx2_r);
  assign sum_y = SUMW'(ty1_r) + SUMW'(ty2_r);
  assign sum_z = SUMW'(tz1_r) - SUMW'(tz2_r);

  // q30 to q1.(OUT_BITS-1): round half up, then clamp symmetric
  function automatic comp_t to_out(input sum_t v);
    logic signed [RW-1:0] e;
    logic signed [RW-1:0] r;
    e = RW'(v);
    if (OUT_BITS <= 30) begin
      r = (e + (RW'(1) <<< (30 - OUT_BITS))) >>> (31 - OUT_BITS);
    end else if (OUT_BITS == 31) begin
      r = e;
    end else begin
      r = e <<< 1;
    end
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      w_r <= to_out(sum_w);
      x_r <= to_out(sum_x);
      y_r <= to_out(sum_y);
      z_r <= to_out(sum_z);
    end
  end

  assign dn_valid = vc_r;
  assign dn_w = w_r;
  assign dn_x = x_r;
  assign dn_y = y_r;
  assign dn_z = z_r;

endmodule

// File: src/euler_to_quaternion.sv
// euler angles (zyx, yaw-pitch-roll) to unit quaternion
//
// input channel: in_valid/in_ready with roll, pitch and yaw as signed binary
// angles, 2^(ANGLE_BITS-1) standing for pi. result channel: out_valid/out_ready
// with w, x, y, z in signed q1.(OUT_BITS-1), clamped to +-(2^(OUT_BITS-1)-1).
// one result word per input word, in order.
//
// the half-angle sines and cosines come from a row of CORDIC_STEPS cordic
// cells, one rotation per cell for all three angles side by side, followed by
// two multiplier stages and one rounding stage. one word is taken every cycle
// unless a stalled receiver has let the pipeline fill.
//
// every stage holds its own valid bit and moves when the stage after it is
// empty or moving, so a stalled receiver first lets the empty slots fill and
// only then drops in_ready. reset clears all valid bits; the pipeline is empty
// and in_ready is high right after reset.
module euler_to_quaternion #(
  parameter int ANGLE_BITS   = euq_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS     = euq_pkg::OUT_BITS_DEF,
  parameter int CORDIC_STEPS = euq_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   out_quat_w,
  output logic signed [OUT_BITS-1:0]   out_quat_x,
  output logic signed [OUT_BITS-1:0]   out_quat_y,
  output logic signed [OUT_BITS-1:0]   out_quat_z
);

  localparam int ZW = euq_pkg::ZW;
  localparam int EW = ZW + 1;

  logic            chain_valid [CORDIC_STEPS+1];
  logic            chain_ready [CORDIC_STEPS+1];
  euq_pkg::lanes_t chain_data  [CORDIC_STEPS+1];
  euq_pkg::lanes_t in_lanes;

  // half angle in phase units: angle * 2^(32-ANGLE_BITS) / 2, floor
  function automatic logic signed [ZW-1:0] half_phase(
    input logic signed [ANGLE_BITS-1:0] a
  );
    logic signed [EW-1:0] e;
    e = EW'(a) <<< (32 - ANGLE_BITS);
    return e[EW-1:1];
  endfunction

  always_comb begin
    in_lanes[euq_pkg::LANE_ROLL].z  = half_phase(in_roll_angle);
    in_lanes[euq_pkg::LANE_PITCH].z = half_phase(in_pitch_angle);
    in_lanes[euq_pkg::LANE_YAW].z   = half_phase(in_yaw_angle);
    for (int l = 0; l < 3; l++) begin
      in_lanes[l].x = euq_pkg::CORDIC_X0;
      in_lanes[l].y = '0;
    end
  end

  assign chain_data[0] = in_lanes;
  assign chain_valid[0] = in_valid;
  assign in_ready = chain_ready[0];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    euq_cordic_cell #(
      .STEP(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  euq_combine #(
    .OUT_BITS(OUT_BITS)
  ) u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[CORDIC_STEPS]),
    .up_ready (chain_ready[CORDIC_STEPS]),
    .up_data  (chain_data[CORDIC_STEPS]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_w     (out_quat_w),
    .dn_x     (out_quat_x),
    .dn_y     (out_quat_y),
    .dn_z     (out_quat_z)
  );

endmodule

// File: src/euq_checker.sv
module euq_checker #(
  parameter int OUT_BITS = euq_pkg::OUT_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_BITS-1:0] out_quat_w,
  input logic signed [OUT_BITS-1:0] out_quat_x,
  input logic signed [OUT_BITS-1:0] out_quat_y,
  input logic signed [OUT_BITS-1:0] out_quat_z
);

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_quat_w) && $stable(out_quat_x) &&
                                $stable(out_quat_y) && $stable(out_quat_z))
    else $error("result word changed while stalled");

  // clamp is symmetric, the most negative code never appears
  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quat_w != MOST_NEG && out_quat_x != MOST_NEG &&
                  out_quat_y != MOST_NEG && out_quat_z != MOST_NEG)
    else $error("component outside symmetric range");

  // a free output slot lets every stage move
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output side is free");

endmodule

bind euler_to_quaternion euq_checker #(
  .OUT_BITS(OUT_BITS)
) u_euq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_quat_w (out_quat_w),
  .out_quat_x (out_quat_x),
  .out_quat_y (out_quat_y),
  .out_quat_z (out_quat_z)
);
